FILE: sv/s5hp_pkg.sv
package s5hp_pkg;

  // Default message length limit; the byte counter saturates here.
  localparam int MAX_MESSAGE_BYTES_DEF = 1023;

  // Depth of the result queue between the parser and the output port.
  localparam int RESULT_DEPTH = 4;

  localparam logic [7:0] SOCKS_VERSION = 8'd5;
  localparam logic [7:0] CMD_CONNECT   = 8'd1;

  localparam logic [7:0] ATYP_IPV4   = 8'd1;
  localparam logic [7:0] ATYP_DOMAIN = 8'd3;
  localparam logic [7:0] ATYP_IPV6   = 8'd4;

  localparam logic [7:0] METHOD_NONE = 8'd0;

  localparam logic [2:0] PHASE_METHOD   = 3'd0;
  localparam logic [2:0] PHASE_CREDS    = 3'd1;
  localparam logic [2:0] PHASE_REQUEST  = 3'd2;
  localparam logic [2:0] PHASE_COMPLETE = 3'd3;
  localparam logic [2:0] PHASE_ERROR    = 3'd4;

  localparam logic [1:0] KIND_ADDRESS  = 2'd0;
  localparam logic [1:0] KIND_USERNAME = 2'd1;
  localparam logic [1:0] KIND_PASSWORD = 2'd2;
  localparam logic [1:0] KIND_VERDICT  = 2'd3;

  localparam logic [1:0] REPLY_SUCCEEDED   = 2'd0;
  localparam logic [1:0] REPLY_GENERAL     = 2'd1;
  localparam logic [1:0] REPLY_COMMAND     = 2'd2;
  localparam logic [1:0] REPLY_ADDRESS     = 2'd3;

  localparam logic OP_BYTE  = 1'b0;
  localparam logic OP_FORCE = 1'b1;

  typedef struct packed {
    logic       op;
    logic [7:0] data;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  payload;
    logic [1:0]  reply;
    logic [2:0]  phase;
    logic [7:0]  address_type;
    logic [15:0] port;
    logic        username_ok;
    logic        password_ok;
    logic        last;
  } out_item_t;

  // Results produced by one accepted byte, in delivery order.
  typedef struct packed {
    logic [1:0] count;
    out_item_t  first;
    out_item_t  second;
  } push_t;

endpackage

FILE: sv/s5hp_core.sv
module s5hp_core #(
  parameter int MAX_MESSAGE_BYTES = s5hp_pkg::MAX_MESSAGE_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  s5hp_pkg::in_item_t  item,
  input  logic [7:0]          required_method,
  output s5hp_pkg::push_t     push
);

  localparam int IW = $clog2(MAX_MESSAGE_BYTES + 1);
  localparam int W  = IW + 1;
  localparam logic [IW-1:0] MAX_IDX = IW'(MAX_MESSAGE_BYTES);
  localparam logic [W-1:0]  MAX_W   = W'(MAX_MESSAGE_BYTES);

  logic [2:0]    phase_reg;
  logic [IW-1:0] byte_index;
  logic [7:0]    first_len;
  logic [7:0]    second_len;
  logic [2:0]    check_flags;
  logic [7:0]    saved_type;
  logic [15:0]   saved_port;
  logic [7:0]    prev_byte;

  logic [7:0]    first_len_next;
  logic [7:0]    second_len_next;
  logic [2:0]    check_flags_next;
  logic [7:0]    saved_type_next;
  logic [15:0]   saved_port_next;
  logic [IW-1:0] byte_index_next;
  logic [2:0]    phase_next;

  logic          live;
  logic [W-1:0]  pw;
  logic [W-1:0]  fl_w;
  logic [W-1:0]  sl_w;
  logic [W-1:0]  len;
  logic [W-1:0]  need;
  logic          sat;
  logic          stream;
  logic [1:0]    stream_kind;
  logic [1:0]    reply;
  logic          uok;
  logic          pok;
  logic          success;

  assign live = byte_index < MAX_IDX;
  assign pw   = W'(byte_index);

  always_comb begin
    first_len_next   = first_len;
    second_len_next  = second_len;
    check_flags_next = check_flags;
    stream           = 1'b0;
    stream_kind      = s5hp_pkg::KIND_ADDRESS;
    fl_w             = W'(first_len);
    sl_w             = W'(second_len);
    if (live) begin
      case (phase_reg)
        s5hp_pkg::PHASE_METHOD: begin
          if (pw == W'(0) && item.data == s5hp_pkg::SOCKS_VERSION) begin
            check_flags_next[0] = 1'b1;
          end
          if (pw == W'(1)) begin
            first_len_next = item.data;
          end
          if (pw >= W'(2) && item.data == required_method) begin
            check_flags_next[2] = 1'b1;
          end
        end
        s5hp_pkg::PHASE_CREDS: begin
          if (pw == W'(1)) begin
            first_len_next = item.data;
          end else if (pw >= W'(2) && pw <= W'(1) + fl_w) begin
            stream      = 1'b1;
            stream_kind = s5hp_pkg::KIND_USERNAME;
          end else if (pw == W'(2) + fl_w) begin
            second_len_next = item.data;
          end else if (pw >= W'(3) + fl_w && pw <= W'(2) + fl_w + sl_w) begin
            stream      = 1'b1;
            stream_kind = s5hp_pkg::KIND_PASSWORD;
          end
        end
        s5hp_pkg::PHASE_REQUEST: begin
          if (pw == W'(0) && item.data == s5hp_pkg::SOCKS_VERSION) begin
            check_flags_next[0] = 1'b1;
          end
          if (pw == W'(1) && item.data == s5hp_pkg::CMD_CONNECT) begin
            check_flags_next[1] = 1'b1;
          end
          if (pw == W'(3)) begin
            first_len_next = item.data;
          end
          if (pw == W'(4)) begin
            second_len_next = item.data;
          end
          if (pw >= W'(4)) begin
            case (first_len_next)
              s5hp_pkg::ATYP_IPV4:   stream = pw <= W'(7);
              s5hp_pkg::ATYP_IPV6:   stream = pw <= W'(19);
              s5hp_pkg::ATYP_DOMAIN: stream = pw >= W'(5) &&
                                              pw <= W'(4) + W'(second_len_next);
              default:               stream = 1'b0;
            endcase
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign len             = live ? pw + W'(1) : MAX_W;
  assign sat             = len >= MAX_W;
  assign byte_index_next = len[IW-1:0];

  always_comb begin
    logic [W-1:0] fln;
    logic [W-1:0] sln;
    fln             = W'(first_len_next);
    sln             = W'(second_len_next);
    reply           = s5hp_pkg::REPLY_GENERAL;
    phase_next      = s5hp_pkg::PHASE_ERROR;
    uok             = 1'b0;
    pok             = 1'b0;
    success         = 1'b0;
    need            = '0;
    saved_type_next = saved_type;
    saved_port_next = saved_port;
    if (len >= W'(3)) begin
      case (phase_reg)
        s5hp_pkg::PHASE_METHOD: begin
          if (check_flags_next[0] && !sat && fln == len - W'(2) &&
              check_flags_next[2]) begin
            reply      = s5hp_pkg::REPLY_SUCCEEDED;
            phase_next = (required_method == s5hp_pkg::METHOD_NONE) ?
                         s5hp_pkg::PHASE_REQUEST : s5hp_pkg::PHASE_CREDS;
          end
        end
        s5hp_pkg::PHASE_CREDS: begin
          reply      = s5hp_pkg::REPLY_SUCCEEDED;
          phase_next = s5hp_pkg::PHASE_CREDS;
          uok        = !sat && fln < len - W'(2);
          pok        = uok && sln == len - W'(3) - fln;
        end
        s5hp_pkg::PHASE_REQUEST: begin
          if (len >= W'(4) && check_flags_next[0]) begin
            if (!check_flags_next[1]) begin
              reply = s5hp_pkg::REPLY_COMMAND;
            end else begin
              case (first_len_next)
                s5hp_pkg::ATYP_IPV4:   need = W'(10);
                s5hp_pkg::ATYP_IPV6:   need = W'(22);
                s5hp_pkg::ATYP_DOMAIN: need = W'(7) + sln;
                default:               need = '0;
              endcase
              if (need == '0) begin
                reply = s5hp_pkg::REPLY_ADDRESS;
              end else if (!sat && len == need) begin
                reply           = s5hp_pkg::REPLY_SUCCEEDED;
                phase_next      = s5hp_pkg::PHASE_COMPLETE;
                success         = 1'b1;
                saved_type_next = first_len_next;
                saved_port_next = {prev_byte, item.data};
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg   <= s5hp_pkg::PHASE_METHOD;
      byte_index  <= '0;
      first_len   <= '0;
      second_len  <= '0;
      check_flags <= '0;
      saved_type  <= '0;
      saved_port  <= '0;
      prev_byte   <= '0;
    end else if (accept) begin
      if (item.op == s5hp_pkg::OP_FORCE || item.end_of_message) begin
        byte_index  <= '0;
        first_len   <= '0;
        second_len  <= '0;
        check_flags <= '0;
        prev_byte   <= '0;
        if (item.op == s5hp_pkg::OP_FORCE) begin
          phase_reg <= item.data[2:0];
        end else begin
          phase_reg <= phase_next;
          if (success) begin
            saved_type <= saved_type_next;
            saved_port <= saved_port_next;
          end
        end
      end else begin
        byte_index  <= byte_index_next;
        first_len   <= first_len_next;
        second_len  <= second_len_next;
        check_flags <= check_flags_next;
        prev_byte   <= item.data;
      end
    end
  end

  s5hp_pkg::out_item_t stream_res;
  s5hp_pkg::out_item_t verdict_res;

  always_comb begin
    stream_res.kind         = stream_kind;
    stream_res.payload      = item.data;
    stream_res.reply        = s5hp_pkg::REPLY_SUCCEEDED;
    stream_res.phase        = phase_reg;
    stream_res.address_type = saved_type;
    stream_res.port         = saved_port;
    stream_res.username_ok  = 1'b0;
    stream_res.password_ok  = 1'b0;
    stream_res.last         = !item.end_of_message;

    verdict_res.kind         = s5hp_pkg::KIND_VERDICT;
    verdict_res.payload      = '0;
    verdict_res.reply        = reply;
    verdict_res.phase        = phase_next;
    verdict_res.address_type = saved_type_next;
    verdict_res.port         = saved_port_next;
    verdict_res.username_ok  = uok;
    verdict_res.password_ok  = pok;
    verdict_res.last         = 1'b1;
  end

  always_comb begin
    if (accept && item.op == s5hp_pkg::OP_BYTE) begin
      push.count = {1'b0, stream} + {1'b0, item.end_of_message};
    end else begin
      push.count = 2'd0;
    end
    push.first  = stream ? stream_res : verdict_res;
    push.second = verdict_res;
  end

endmodule

FILE: sv/s5hp_result_fifo.sv
module s5hp_result_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  s5hp_pkg::push_t      push,
  output logic                 full,
  output logic                 valid,
  input  logic                 stall,
  output s5hp_pkg::out_item_t  head
);

  localparam int DEPTH = s5hp_pkg::RESULT_DEPTH;
  localparam int PW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  s5hp_pkg::out_item_t entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic          pop;

  assign valid = count != '0;
  assign pop   = valid && !stall;
  assign head  = entries[rd_ptr];
  // Room for the two results a single byte can cause must always be there.
  assign full  = count > CW'(DEPTH - 2);

  assign count_next = count + CW'(push.count) - CW'(pop);

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      entries[wr_ptr + PW'(1)] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PW'(push.count);
      rd_ptr <= rd_ptr + PW'(pop);
      count  <= count_next;
    end
  end

endmodule

FILE: sv/socks5_handshake_parser.sv
// SOCKS5 handshake parser. Handshake messages arrive one byte per beat on the
// byte channel, with end_of_message set on the last byte of each message; a
// beat with op set instead forces the phase to data[2:0] and restarts the
// message. The parser accepts one beat every clock cycle while the result queue
// has room: each byte is parsed in the cycle it is accepted and its zero, one
// or two results are written to a four-entry result queue. Sustained input
// rate is one beat per cycle as long as results are drained; a byte that both
// streams an address or credential byte and ends the message yields two
// results, and the result port drains one per cycle while not stalled, so the
// input stalls once the queue cannot take two more results.
// The required authentication method is written through the cfg channel,
// which is always ready; write it only while the parser is idle.

module socks5_handshake_parser #(
  parameter int MAX_MESSAGE_BYTES = s5hp_pkg::MAX_MESSAGE_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst,

  input  logic                byte_valid,
  output logic                byte_stall,
  input  s5hp_pkg::in_item_t  byte_item,

  output logic                result_valid,
  input  logic                result_stall,
  output s5hp_pkg::out_item_t result_item,

  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_data
);

  // The single configuration register; writes complete in one beat.
  logic [7:0] required_method;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      required_method <= s5hp_pkg::METHOD_NONE;
    end else if (cfg_valid && cfg_ready) begin
      required_method <= cfg_data;
    end
  end

  // A byte is taken whenever it is offered and the queue has room for the
  // worst case of two results.
  logic            accept;
  logic            queue_full;
  s5hp_pkg::push_t push;

  assign byte_stall = queue_full;
  assign accept     = byte_valid && !byte_stall;

  // Phase tracking, length checks and the verdict all happen here in the
  // accepting cycle.
  s5hp_core #(
    .MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)
  ) u_core (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .item           (byte_item),
    .required_method(required_method),
    .push           (push)
  );

  // The queue decouples the two sides, so a stalled result never blocks the
  // next byte until the queue is nearly full.
  s5hp_result_fifo u_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (queue_full),
    .valid(result_valid),
    .stall(result_stall),
    .head (result_item)
  );

endmodule

FILE: sv/s5hp_checker.sv
module s5hp_checker (
  input logic                clk,
  input logic                rst,
  input logic                byte_valid,
  input logic                byte_stall,
  input logic                result_valid,
  input logic                result_stall,
  input s5hp_pkg::out_item_t result_item
);

  // A stalled result holds.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result_item))
    else $error("stalled result changed");

  // Results only appear right after an accepted byte.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !$past(result_valid) && !$past(rst) |->
      $past(byte_valid && !byte_stall))
    else $error("result appeared without an accepted byte");

  // Streamed bytes carry no verdict information.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_item.kind != s5hp_pkg::KIND_VERDICT |->
      result_item.reply == s5hp_pkg::REPLY_SUCCEEDED &&
      !result_item.username_ok && !result_item.password_ok)
    else $error("streamed byte carries verdict fields");

  // Any failure reply moves to the error phase; verdicts always close a result run.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_item.kind == s5hp_pkg::KIND_VERDICT |->
      result_item.last && result_item.payload == 8'd0 &&
      ((result_item.reply == s5hp_pkg::REPLY_SUCCEEDED) ==
       (result_item.phase != s5hp_pkg::PHASE_ERROR)))
    else $error("verdict reply and phase disagree");

endmodule

bind socks5_handshake_parser s5hp_checker u_checker (.*);

FILE: verif/s5hp_result_check.sv
module s5hp_result_check
  import s5hp_pkg::*;
#(
  parameter int MAX_BYTES = MAX_MESSAGE_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      byte_valid,
  input  logic      byte_stall,
  input  in_item_t  byte_item,
  input  logic      result_valid,
  input  logic      result_stall,
  input  out_item_t result_item,
  input  logic      cfg_valid,
  input  logic      cfg_ready,
  input  logic [7:0] cfg_data,
  output int        fail_count,
  output int        pending_results
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow of the parser state.
  logic [7:0]  req_method;
  logic [2:0]  cur_phase;
  int unsigned msg_pos;
  logic [7:0]  len_a;
  logic [7:0]  len_b;
  logic        ver_seen;
  logic        cmd_seen;
  logic        method_seen;
  logic [7:0]  atyp_kept;
  logic [15:0] port_kept;
  logic [7:0]  prev_data;

  out_item_t expected_results[$];
  int        mismatches = 0;

  assign fail_count      = mismatches;
  assign pending_results = expected_results.size();

  function automatic void clear_message();
    msg_pos     = 0;
    len_a       = '0;
    len_b       = '0;
    ver_seen    = 1'b0;
    cmd_seen    = 1'b0;
    method_seen = 1'b0;
    prev_data   = '0;
  endfunction

  function automatic out_item_t make_result(logic [1:0] k, logic [7:0] pl, logic [1:0] rp,
                                            logic uok, logic pok, logic lst);
    out_item_t r;
    r.kind         = k;
    r.payload      = pl;
    r.reply        = rp;
    r.phase        = cur_phase;
    r.address_type = atyp_kept;
    r.port         = port_kept;
    r.username_ok  = uok;
    r.password_ok  = pok;
    r.last         = lst;
    return r;
  endfunction

  task automatic predict_beat(in_item_t b);
    int unsigned pos, msg_len, need, ulen, blen;
    logic        sat, addr, uok, pok;
    logic [1:0]  rp;
    logic [2:0]  next_phase;
    logic [7:0]  d;
    d = b.data;
    if (b.op == OP_FORCE) begin
      cur_phase = d[2:0];
      clear_message();
      return;
    end
    pos = msg_pos;
    if (pos < MAX_BYTES) begin
      case (cur_phase)
        PHASE_METHOD: begin
          if (pos == 0 && d == SOCKS_VERSION) ver_seen = 1'b1;
          if (pos == 1) len_a = d;
          if (pos >= 2 && d == req_method) method_seen = 1'b1;
        end
        PHASE_CREDS: begin
          ulen = 32'(len_a);
          blen = 32'(len_b);
          if (pos == 1) begin
            len_a = d;
          end else if (pos >= 2 && pos <= 1 + ulen) begin
            expected_results.push_back(make_result(KIND_USERNAME, d, REPLY_SUCCEEDED,
                                                   1'b0, 1'b0, !b.end_of_message));
          end else if (pos == 2 + ulen) begin
            len_b = d;
          end else if (pos >= 3 + ulen && pos <= 2 + ulen + blen) begin
            expected_results.push_back(make_result(KIND_PASSWORD, d, REPLY_SUCCEEDED,
                                                   1'b0, 1'b0, !b.end_of_message));
          end
        end
        PHASE_REQUEST: begin
          if (pos == 0 && d == SOCKS_VERSION) ver_seen = 1'b1;
          if (pos == 1 && d == CMD_CONNECT) cmd_seen = 1'b1;
          if (pos == 3) len_a = d;
          if (pos == 4) len_b = d;
          blen = 32'(len_b);
          addr = 1'b0;
          if (pos >= 4) begin
            case (len_a)
              ATYP_IPV4:   addr = (pos <= 7);
              ATYP_IPV6:   addr = (pos <= 19);
              ATYP_DOMAIN: addr = (pos >= 5 && pos <= 4 + blen);
              default:     addr = 1'b0;
            endcase
          end
          if (addr) begin
            expected_results.push_back(make_result(KIND_ADDRESS, d, REPLY_SUCCEEDED,
                                                   1'b0, 1'b0, !b.end_of_message));
          end
        end
        default: ;
      endcase
    end

    msg_len = (pos < MAX_BYTES) ? pos + 1 : MAX_BYTES;
    sat     = (msg_len >= MAX_BYTES);
    msg_pos = msg_len;
    if (!b.end_of_message) begin
      prev_data = d;
      return;
    end

    rp         = REPLY_GENERAL;
    next_phase = PHASE_ERROR;
    uok        = 1'b0;
    pok        = 1'b0;
    ulen       = 32'(len_a);
    blen       = 32'(len_b);
    if (cur_phase <= PHASE_REQUEST && msg_len >= 3) begin
      case (cur_phase)
        PHASE_METHOD: begin
          if (ver_seen && !sat && ulen == msg_len - 2 && method_seen) begin
            rp         = REPLY_SUCCEEDED;
            next_phase = (req_method == METHOD_NONE) ? PHASE_REQUEST : PHASE_CREDS;
          end
        end
        PHASE_CREDS: begin
          rp         = REPLY_SUCCEEDED;
          next_phase = PHASE_CREDS;
          uok        = !sat && (ulen < msg_len - 2);
          pok        = uok && (blen == msg_len - 3 - ulen);
        end
        default: begin
          if (msg_len >= 4 && ver_seen) begin
            if (!cmd_seen) begin
              rp = REPLY_COMMAND;
            end else begin
              case (len_a)
                ATYP_IPV4:   need = 10;
                ATYP_IPV6:   need = 22;
                ATYP_DOMAIN: need = 7 + blen;
                default:     need = 0;
              endcase
              if (need == 0) begin
                rp = REPLY_ADDRESS;
              end else if (!sat && msg_len == need) begin
                rp         = REPLY_SUCCEEDED;
                next_phase = PHASE_COMPLETE;
                atyp_kept  = len_a;
                port_kept  = {prev_data, d};
              end
            end
          end
        end
      endcase
    end
    cur_phase = next_phase;
    expected_results.push_back(make_result(KIND_VERDICT, 8'h00, rp, uok, pok, 1'b1));
    clear_message();
  endtask

  task automatic compare_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_result(out_item_t got);
    out_item_t want;
    if (expected_results.size() == 0) begin
      $error("result beat with nothing expected: kind %0h payload %0h", got.kind, got.payload);
      mismatches++;
      return;
    end
    want = expected_results.pop_front();
    compare_field("kind", 16'(want.kind), 16'(got.kind));
    compare_field("payload", 16'(want.payload), 16'(got.payload));
    compare_field("reply", 16'(want.reply), 16'(got.reply));
    compare_field("phase", 16'(want.phase), 16'(got.phase));
    compare_field("address_type", 16'(want.address_type), 16'(got.address_type));
    compare_field("port", want.port, got.port);
    compare_field("username_ok", 16'(want.username_ok), 16'(got.username_ok));
    compare_field("password_ok", 16'(want.password_ok), 16'(got.password_ok));
    compare_field("last", 16'(want.last), 16'(got.last));
  endtask

  // Results leave the parser only after their byte has been written into the
  // result queue, so checking before predicting within one edge is safe.
  always @(posedge clk) begin
    if (rst) begin
      req_method = METHOD_NONE;
      cur_phase  = PHASE_METHOD;
      atyp_kept  = '0;
      port_kept  = '0;
      clear_message();
      expected_results.delete();
    end else begin
      if (result_valid && !result_stall) check_result(result_item);
      if (cfg_valid && cfg_ready) req_method = cfg_data;
      if (byte_valid && !byte_stall) predict_beat(byte_item);
    end
  end

endmodule

FILE: verif/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import s5hp_pkg::*;

  // Far beyond the slowest legal run: under a thousand beats, each with
  // sender gaps and two results behind a receiver that stalls most cycles.
  localparam int CYCLE_LIMIT = 400000;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      byte_valid;
  logic      byte_stall;
  in_item_t  byte_item;
  logic      result_valid;
  logic      result_stall = 1'b0;
  out_item_t result_item;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [7:0] cfg_data;

  int fail_count;
  int pending_results;

  // Idle percentages for the two sides; changed between phases of the run.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  int         beat_count = 0;
  int         cycle_count = 0;
  logic [7:0] cur_method = METHOD_NONE;

  // Bytes of the message being built, sent front to back.
  logic [7:0] msg[$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  socks5_handshake_parser DUT (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .byte_item    (byte_item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  s5hp_result_check result_check (
    .clk             (clk),
    .rst             (rst),
    .byte_valid      (byte_valid),
    .byte_stall      (byte_stall),
    .byte_item       (byte_item),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .result_item     (result_item),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  // The receiver decides at every falling edge whether to hold off the
  // next result beat.
  always @(negedge clk) begin
    result_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Watchdog: a hung parser or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Presents one beat and returns at the falling edge after it was taken.
  // Valid stays high when the next beat follows right away, so it is only
  // ever assigned once per edge.
  task automatic send_beat(logic op, logic [7:0] d, logic eom);
    while ($urandom_range(99) < send_idle_pct) begin
      byte_valid <= 1'b0;
      @(negedge clk);
    end
    byte_valid <= 1'b1;
    byte_item  <= '{op: op, data: d, end_of_message: eom};
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    beat_count++;
    @(negedge clk);
  endtask

  // Phase override beat; the upper data bits and the end flag are noise the
  // parser must ignore.
  task automatic force_phase(logic [2:0] ph);
    send_beat(OP_FORCE, {5'($urandom_range(31)), ph}, 1'($urandom_range(1)));
  endtask

  // Sends msg with the end flag on its last byte. When breaking is allowed, a
  // phase override now and then lands in the middle of the message.
  task automatic send_message(bit may_break);
    int cut;
    cut = -1;
    if (may_break && msg.size() > 1 && $urandom_range(99) < 4)
      cut = $urandom_range(1, msg.size() - 1);
    foreach (msg[i]) begin
      if (i == cut) force_phase(3'($urandom_range(7)));
      send_beat(OP_BYTE, msg[i], i == msg.size() - 1);
    end
  endtask

  // Lengths for usernames, passwords and domains: mostly short, sometimes
  // close to the one-byte maximum.
  function automatic int pick_len();
    if ($urandom_range(19) == 0) return $urandom_range(200, 255);
    return $urandom_range(0, 12);
  endfunction

  // Method selection: version, method count, then the offered methods. Most
  // of the time the required method is among them.
  function automatic void build_method();
    int n;
    msg.delete();
    n = $urandom_range(1, 8);
    msg.push_back(SOCKS_VERSION);
    msg.push_back(8'(n));
    for (int i = 0; i < n; i++) msg.push_back(8'($urandom_range(255)));
    if ($urandom_range(9) != 0) msg[2 + $urandom_range(n - 1)] = cur_method;
  endfunction

  // Username/password message: subnegotiation version, username, password.
  function automatic void build_creds();
    int ulen, plen;
    msg.delete();
    ulen = pick_len();
    plen = pick_len();
    msg.push_back(8'($urandom_range(255)));
    msg.push_back(8'(ulen));
    repeat (ulen) msg.push_back(8'($urandom_range(255)));
    msg.push_back(8'(plen));
    repeat (plen) msg.push_back(8'($urandom_range(255)));
  endfunction

  // Connect request: version, command, reserved, address type, address and
  // port. A few carry a foreign command or address type.
  function automatic void build_request();
    int sel, dlen;
    msg.delete();
    msg.push_back(SOCKS_VERSION);
    msg.push_back(($urandom_range(9) == 0) ? 8'($urandom_range(255)) : CMD_CONNECT);
    msg.push_back(8'($urandom_range(255)));
    sel = $urandom_range(9);
    if (sel <= 3) begin
      msg.push_back(ATYP_IPV4);
      repeat (4) msg.push_back(8'($urandom_range(255)));
    end else if (sel <= 6) begin
      msg.push_back(ATYP_IPV6);
      repeat (16) msg.push_back(8'($urandom_range(255)));
    end else if (sel <= 8) begin
      dlen = pick_len();
      msg.push_back(ATYP_DOMAIN);
      msg.push_back(8'(dlen));
      repeat (dlen) msg.push_back(8'($urandom_range(255)));
    end else begin
      msg.push_back(8'($urandom_range(255)));
      repeat ($urandom_range(0, 6)) msg.push_back(8'($urandom_range(255)));
    end
    msg.push_back(8'($urandom_range(255)));
    msg.push_back(8'($urandom_range(255)));
  endfunction

  // Breaks a well-formed message: cut it short, pad it, or overwrite a byte.
  function automatic void corrupt_message();
    int drop;
    case ($urandom_range(2))
      0: begin
        drop = $urandom_range(msg.size() - 1);
        repeat (drop) void'(msg.pop_back());
      end
      1: repeat ($urandom_range(1, 3)) msg.push_back(8'($urandom_range(255)));
      default: msg[$urandom_range(msg.size() - 1)] = 8'($urandom_range(255));
    endcase
  endfunction

  // One handshake from method selection to the connect request. The
  // credential verdict never moves on to the request by itself, so the server
  // side moves the parser on to the request with an override, as a real
  // server would after checking the credentials.
  task automatic run_session();
    force_phase(PHASE_METHOD);
    build_method();
    if ($urandom_range(99) < 12) corrupt_message();
    send_message(1'b1);
    if (cur_method != METHOD_NONE) begin
      build_creds();
      if ($urandom_range(99) < 12) corrupt_message();
      send_message(1'b1);
      force_phase(PHASE_REQUEST);
    end
    build_request();
    if ($urandom_range(99) < 12) corrupt_message();
    send_message(1'b1);
  endtask

  // Waits until every expected result is back, then keeps waiting on the clock
  // for override beats that produce no result.
  task automatic settle();
    byte_valid <= 1'b0;
    do @(negedge clk); while (pending_results != 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_method(logic [7:0] value);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid  <= 1'b0;
    cur_method = value;
  endtask

  // Random phase: mostly complete handshakes and some pure noise in an
  // arbitrary phase, until the phase has sent its share of beats.
  task automatic run_random_phase(int sender_pct, int receiver_pct, logic [7:0] method);
    int target;
    write_method(method);
    send_idle_pct  = sender_pct;
    recv_stall_pct = receiver_pct;
    target = beat_count + 260;
    while (beat_count < target) begin
      if ($urandom_range(9) == 0) begin
        force_phase(3'($urandom_range(7)));
        repeat ($urandom_range(1, 3)) begin
          msg.delete();
          repeat ($urandom_range(1, 12)) msg.push_back(8'($urandom_range(255)));
          send_message(1'b1);
        end
      end else begin
        run_session();
      end
    end
  endtask

  initial begin
    byte_valid = 1'b0;
    byte_item  = '0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    send_idle_pct  = 20;
    recv_stall_pct = 58;
    write_method(METHOD_NONE);

    // Directed opening. A method message of two bytes is too short.
    msg = '{SOCKS_VERSION, 8'd1};
    send_message(1'b0);
    // Override with every upper data bit set; only the low three bits count.
    send_beat(OP_FORCE, 8'hF8, 1'b1);
    // Minimal method selection with no authentication leads to the request.
    msg = '{SOCKS_VERSION, 8'd1, METHOD_NONE};
    send_message(1'b0);
    // A command other than connect.
    msg = '{SOCKS_VERSION, 8'd2, 8'd0, ATYP_IPV4};
    send_message(1'b0);
    // An address type the parser does not know.
    send_beat(OP_FORCE, {5'd0, PHASE_REQUEST}, 1'b0);
    msg = '{SOCKS_VERSION, CMD_CONNECT, 8'd0, 8'd2};
    send_message(1'b0);
    // A phase beyond the request: counted, not streamed, general failure.
    send_beat(OP_FORCE, 8'h07, 1'b0);
    msg = '{8'hFF};
    send_message(1'b0);
    // Smallest credential message: empty username and password, both valid.
    send_beat(OP_FORCE, {5'd0, PHASE_CREDS}, 1'b0);
    msg = '{8'h01, 8'h00, 8'h00};
    send_message(1'b0);

    // Random phases with the idle pattern swapped between the two sides, then
    // full rate. The required method walks through its extremes.
    run_random_phase(20, 58, 8'hFF);
    run_random_phase(58, 20, 8'($urandom_range(1, 254)));
    run_random_phase(0, 0, METHOD_NONE);

    settle();
    if (fail_count == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
